>>> hw/rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES package
// Shared types, constants and byte-level functions for the AES-256 core.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int NumRounds = 14;
    localparam int NumRoundKeys = 15;
    localparam int NumKeyWords = 60;
    localparam int KeyExpandSteps = 52;

    typedef logic [127:0] block_t;
    typedef logic [255:0] key_t;

    typedef enum logic [1:0] {
        CFG_KEY_WORD_0 = 2'd0,
        CFG_KEY_WORD_1 = 2'd1,
        CFG_KEY_WORD_2 = 2'd2,
        CFG_KEY_WORD_3 = 2'd3
    } cfg_index_t;

    typedef enum logic {
        CMD_ENCRYPT = 1'b0,
        CMD_DECRYPT = 1'b1
    } cmd_t;

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ x;
            x = xt(x);
        end
        gmul = p;
    endfunction

    function automatic logic [7:0] ginv(input logic [7:0] x);
        logic [7:0] r;
        logic [7:0] b;
        r = 8'h01;
        b = x;
        // x^254: exponent bits 1..7 set, bit 0 clear.
        for (int i = 0; i < 8; i++) begin
            if (i != 0) r = gmul(r, b);
            b = gmul(b, b);
        end
        ginv = r;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
        logic [15:0] d;
        d = {v, v} << n;
        rotl8 = d[15:8];
    endfunction

    function automatic logic [7:0] sbox_calc(input logic [7:0] x);
        logic [7:0] y;
        y = ginv(x);
        sbox_calc = y ^ rotl8(y, 1) ^ rotl8(y, 2) ^ rotl8(y, 3) ^ rotl8(y, 4) ^ 8'h63;
    endfunction

    function automatic logic [7:0] sbox_inv_calc(input logic [7:0] x);
        logic [7:0] y;
        y = x ^ 8'h63;
        sbox_inv_calc = ginv(rotl8(y, 1) ^ rotl8(y, 3) ^ rotl8(y, 6));
    endfunction

    // Constant tables built at elaboration.
    function automatic logic [255:0][7:0] build_sbox(input logic inv);
        logic [255:0][7:0] t;
        for (int i = 0; i < 256; i++) begin
            t[i] = inv ? sbox_inv_calc(8'(i)) : sbox_calc(8'(i));
        end
        build_sbox = t;
    endfunction

    localparam logic [255:0][7:0] SboxFwd = build_sbox(1'b0);
    localparam logic [255:0][7:0] SboxInv = build_sbox(1'b1);

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SboxFwd[w[31:24]], SboxFwd[w[23:16]], SboxFwd[w[15:8]], SboxFwd[w[7:0]]};
    endfunction

    // Byte i of the state sits at bits 127-8i.
    function automatic logic [7:0] get_b(input block_t s, input int i);
        get_b = s[127 - 8*i -: 8];
    endfunction

    function automatic block_t sub_shift_fwd(input block_t s);
        block_t t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(r + 4*c) -: 8] = SboxFwd[get_b(s, r + 4*((c + r) % 4))];
            end
        end
        sub_shift_fwd = t;
    endfunction

    function automatic block_t sub_shift_inv(input block_t s);
        block_t t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(r + 4*((c + r) % 4)) -: 8] = SboxInv[get_b(s, r + 4*c)];
            end
        end
        sub_shift_inv = t;
    endfunction

    function automatic block_t mix_fwd(input block_t s);
        block_t t;
        logic [7:0] a, b, d, e, x;
        for (int c = 0; c < 4; c++) begin
            a = get_b(s, 4*c);
            b = get_b(s, 4*c + 1);
            d = get_b(s, 4*c + 2);
            e = get_b(s, 4*c + 3);
            x = a ^ b ^ d ^ e;
            t[127 - 32*c -: 8] = a ^ x ^ xt(a ^ b);
            t[119 - 32*c -: 8] = b ^ x ^ xt(b ^ d);
            t[111 - 32*c -: 8] = d ^ x ^ xt(d ^ e);
            t[103 - 32*c -: 8] = e ^ x ^ xt(e ^ a);
        end
        mix_fwd = t;
    endfunction

    function automatic block_t mix_inv(input block_t s);
        block_t t;
        logic [7:0] a, b, d, e;
        for (int c = 0; c < 4; c++) begin
            a = get_b(s, 4*c);
            b = get_b(s, 4*c + 1);
            d = get_b(s, 4*c + 2);
            e = get_b(s, 4*c + 3);
            t[127 - 32*c -: 8] = gmul(a, 8'd14) ^ gmul(b, 8'd11) ^ gmul(d, 8'd13) ^ gmul(e, 8'd9);
            t[119 - 32*c -: 8] = gmul(a, 8'd9) ^ gmul(b, 8'd14) ^ gmul(d, 8'd11) ^ gmul(e, 8'd13);
            t[111 - 32*c -: 8] = gmul(a, 8'd13) ^ gmul(b, 8'd9) ^ gmul(d, 8'd14) ^ gmul(e, 8'd11);
            t[103 - 32*c -: 8] = gmul(a, 8'd11) ^ gmul(b, 8'd13) ^ gmul(d, 8'd9) ^ gmul(e, 8'd14);
        end
        mix_inv = t;
    endfunction

endpackage

>>> hw/rtl/aes256_block_cipher.sv
// ----------------------------------------------------------------------------
// AES-256 block cipher
// Fully unrolled AES-256 ECB core with encrypt and decrypt per block.
// ----------------------------------------------------------------------------
// The key is loaded through the configuration channel as four 64-bit words
// (index 0 holds key bytes 0..7). The user must load it only while no block
// is in flight; the core does not enforce this. After reset and after every
// key write the round keys are expanded; during that time cfg_ready and
// s_ready are low. Each transfer on the s_ channel carries a command
// (0 encrypt, 1 decrypt) and one block; exactly one m_ transfer returns the
// transformed block, in order. The core has one input register for the
// initial key addition and fourteen round registers, which a block passes
// through in that order before m_valid rises.
// One block enters per cycle when the output is taken every cycle.
// When m_ready is low with the last stage full, the whole pipeline holds and
// s_ready drops; no data is lost or repeated.
// Reset clears all stage valid bits and the key registers to zero.
// ----------------------------------------------------------------------------
module aes256_block_cipher
    import aes_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [63:0] s_block_high,
    input  logic [63:0] s_block_low,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_high,
    output logic [63:0] m_result_low
);

    block_t [NumRoundKeys-1:0] round_keys;
    logic   [NumRounds:0]      vld;
    logic   [NumRounds:0]      dec;
    block_t [NumRounds:0]      st;
    logic   advance;
    logic   key_ready;
    logic   v0_reg;
    logic   d0_reg;
    block_t s0_reg;
    block_t in_blk;

    assign cfg_ready = key_ready;
    assign advance   = m_ready || !vld[NumRounds];
    assign s_ready   = advance && key_ready;
    assign in_blk    = {s_block_high, s_block_low};

    aes_key_sched u_key (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .key_ready  (key_ready),
        .round_keys (round_keys)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (advance) begin
            v0_reg <= s_valid && key_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            d0_reg <= s_command;
            s0_reg <= in_blk ^ (s_command ? round_keys[NumRounds] : round_keys[0]);
        end
    end

    assign vld[0] = v0_reg;
    assign dec[0] = d0_reg;
    assign st[0]  = s0_reg;

    for (genvar r = 1; r <= NumRounds; r++) begin : g_round
        aes_round #(.Round(r)) u_round (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .advance    (advance),
            .in_valid   (vld[r-1]),
            .in_dec     (dec[r-1]),
            .in_state   (st[r-1]),
            .round_keys (round_keys),
            .out_valid  (vld[r]),
            .out_dec    (dec[r]),
            .out_state  (st[r])
        );
    end

    assign m_valid       = vld[NumRounds];
    assign m_result_high = st[NumRounds][127:64];
    assign m_result_low  = st[NumRounds][63:0];

endmodule

>>> hw/rtl/aes_key_sched.sv
// ----------------------------------------------------------------------------
// AES key schedule
// Holds the key registers and expands them into the fifteen round keys,
// one schedule word per cycle. After reset and after every key write
// key_ready is low through the key load and the whole expansion.
// ----------------------------------------------------------------------------
module aes_key_sched
    import aes_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [63:0]                  cfg_data,
    output logic                         key_ready,
    output block_t [NumRoundKeys-1:0]    round_keys
);

    logic [3:0][63:0]             key_reg;
    logic [NumKeyWords-1:0][31:0] w_reg;
    logic                         load_reg;
    logic                         run_reg;
    logic [5:0]                   step_reg;
    logic [7:0]                   rc_reg;
    logic [31:0]                  sched_word;
    logic [31:0]                  new_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_KEY_WORD_0: key_reg[0] <= cfg_data;
                CFG_KEY_WORD_1: key_reg[1] <= cfg_data;
                CFG_KEY_WORD_2: key_reg[2] <= cfg_data;
                CFG_KEY_WORD_3: key_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg <= 1'b1;
            run_reg  <= 1'b0;
            step_reg <= '0;
            rc_reg   <= 8'h01;
        end else if (cfg_we) begin
            load_reg <= 1'b1;
            run_reg  <= 1'b0;
        end else if (load_reg) begin
            load_reg <= 1'b0;
            run_reg  <= 1'b1;
            step_reg <= '0;
            rc_reg   <= 8'h01;
        end else if (run_reg) begin
            step_reg <= step_reg + 6'd1;
            // The round constant advances once per rotated word.
            if (step_reg[2:0] == 3'd0) rc_reg <= xt(rc_reg);
            if (step_reg == 6'(KeyExpandSteps - 1)) run_reg <= 1'b0;
        end
    end

    // The key words enter at the top of a shift register; each step shifts
    // in one new word, so the newest word is always at the top and the word
    // eight positions back sits at a fixed place.
    always_ff @(posedge aclk) begin
        if (load_reg) begin
            for (int j = 0; j < 8; j++) begin
                w_reg[NumKeyWords - 8 + j] <= (j % 2 == 0) ? key_reg[j/2][63:32]
                                                            : key_reg[j/2][31:0];
            end
        end else if (run_reg) begin
            for (int j = 0; j < NumKeyWords - 1; j++) begin
                w_reg[j] <= w_reg[j+1];
            end
            w_reg[NumKeyWords-1] <= new_word;
        end
    end

    always_comb begin
        sched_word = w_reg[NumKeyWords-1];
        if (step_reg[2:0] == 3'd0) begin
            sched_word = sub_word({sched_word[23:0], sched_word[31:24]}) ^ {rc_reg, 24'h0};
        end else if (step_reg[2:0] == 3'd4) begin
            sched_word = sub_word(sched_word);
        end
        new_word = w_reg[NumKeyWords-8] ^ sched_word;
    end

    always_comb begin
        for (int r = 0; r < NumRoundKeys; r++) begin
            round_keys[r] = {w_reg[4*r], w_reg[4*r+1], w_reg[4*r+2], w_reg[4*r+3]};
        end
    end

    assign key_ready = !(load_reg || run_reg);

endmodule

>>> hw/rtl/aes_round.sv
// ----------------------------------------------------------------------------
// AES round stage
// One registered cipher round for either direction, with stall support.
// ----------------------------------------------------------------------------
module aes_round
    import aes_pkg::*;
#(
    parameter int Round = 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      advance,
    input  logic                      in_valid,
    input  logic                      in_dec,
    input  block_t                    in_state,
    input  block_t [NumRoundKeys-1:0] round_keys,
    output logic                      out_valid,
    output logic                      out_dec,
    output block_t                    out_state
);

    logic   valid_reg;
    logic   dec_reg;
    block_t state_reg;
    block_t state_next;
    block_t enc_next;
    block_t dec_next;

    // Round 14 is the last: no column mix, and the decrypt side ends on key 0.
    always_comb begin
        enc_next = sub_shift_fwd(in_state);
        if (Round != NumRounds) enc_next = mix_fwd(enc_next);
        enc_next = enc_next ^ round_keys[Round];
        dec_next = sub_shift_inv(in_state) ^ round_keys[NumRounds - Round];
        if (Round != NumRounds) dec_next = mix_inv(dec_next);
        state_next = in_dec ? dec_next : enc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            dec_reg   <= in_dec;
            state_reg <= state_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_dec   = dec_reg;
    assign out_state = state_reg;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// AES-256 block cipher testbench
// Loads several keys, sends known-answer and random blocks in both directions
// with random idle bursts on both channels, and compares every output block
// with a software cipher model in order.
// ----------------------------------------------------------------------------
module tb;
    import aes_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PipeDepth = 15;
    localparam int CycleLimit = 400000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_command;
    logic [63:0] s_block_high;
    logic [63:0] s_block_low;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_result_high;
    logic [63:0] m_result_low;

    aes256_block_cipher uut (.*);

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } block_pair_t;

    typedef struct {
        cmd_t        cmd;
        logic [63:0] hi;
        logic [63:0] lo;
        logic        known;
        logic [63:0] exp_hi;
        logic [63:0] exp_lo;
    } vector_t;

    logic [63:0] key_words [4];
    logic [7:0]  fwd_sbox [256];
    logic [7:0]  inv_sbox [256];
    block_pair_t pending_blocks [$];
    int          errors = 0;
    int          blocks_sent = 0;
    int          blocks_checked = 0;
    int          keys_used = 0;
    int          cycles = 0;
    bit          quiet_tail = 0;

    function automatic logic [7:0] mul2(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = mul2(a);
        end
        return acc;
    endfunction

    // The substitution tables are built by inverting in GF(2^8) by brute
    // force, then applying the affine map.
    task automatic build_sboxes();
        logic [7:0] y, s;
        for (int x = 0; x < 256; x++) begin
            y = 8'h00;
            for (int c = 1; c < 256; c++) begin
                if (x != 0 && gf_mul(8'(x), 8'(c)) == 8'h01) y = 8'(c);
            end
            s = y ^ {y[6:0], y[7]} ^ {y[5:0], y[7:6]} ^ {y[4:0], y[7:5]}
                ^ {y[3:0], y[7:4]} ^ 8'h63;
            fwd_sbox[x] = s;
            inv_sbox[s] = 8'(x);
        end
    endtask

    function automatic logic [31:0] subst_word(input logic [31:0] w);
        return {fwd_sbox[w[31:24]], fwd_sbox[w[23:16]], fwd_sbox[w[15:8]], fwd_sbox[w[7:0]]};
    endfunction

    function automatic block_pair_t aes256_transform(input cmd_t cmd, input logic [63:0] hi,
                                                     input logic [63:0] lo);
        logic [31:0] w [60];
        logic [7:0]  st [16];
        logic [7:0]  tmp [16];
        logic [7:0]  rcon, a, b, d, e, x;
        logic [31:0] t;
        block_pair_t res;
        int          rk;
        rcon = 8'h01;
        for (int i = 0; i < 8; i++) w[i] = 32'(key_words[i / 2] >> ((i % 2) ? 0 : 32));
        for (int i = 8; i < 60; i++) begin
            t = w[i-1];
            if (i % 8 == 0) begin
                t = subst_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
                rcon = mul2(rcon);
            end else if (i % 8 == 4) begin
                t = subst_word(t);
            end
            w[i] = w[i-8] ^ t;
        end
        for (int i = 0; i < 8; i++) begin
            st[i] = hi[63 - 8*i -: 8];
            st[8+i] = lo[63 - 8*i -: 8];
        end
        for (int step = 0; step <= 14; step++) begin
            rk = (cmd == CMD_ENCRYPT) ? step : 14 - step;
            if (step > 0) begin
                // Substitution and row shift, forward or inverse.
                for (int c = 0; c < 4; c++) begin
                    for (int r = 0; r < 4; r++) begin
                        if (cmd == CMD_ENCRYPT)
                            tmp[r + 4*c] = fwd_sbox[st[r + 4*((c + r) % 4)]];
                        else
                            tmp[r + 4*((c + r) % 4)] = inv_sbox[st[r + 4*c]];
                    end
                end
                st = tmp;
                if (cmd == CMD_ENCRYPT && step < 14) begin
                    for (int c = 0; c < 4; c++) begin
                        a = st[4*c]; b = st[4*c+1]; d = st[4*c+2]; e = st[4*c+3];
                        x = a ^ b ^ d ^ e;
                        st[4*c]   = a ^ x ^ mul2(a ^ b);
                        st[4*c+1] = b ^ x ^ mul2(b ^ d);
                        st[4*c+2] = d ^ x ^ mul2(d ^ e);
                        st[4*c+3] = e ^ x ^ mul2(e ^ a);
                    end
                end
            end
            for (int i = 0; i < 16; i++) st[i] ^= w[4*rk + i/4][31 - 8*(i%4) -: 8];
            if (cmd == CMD_DECRYPT && step > 0 && step < 14) begin
                for (int c = 0; c < 4; c++) begin
                    a = st[4*c]; b = st[4*c+1]; d = st[4*c+2]; e = st[4*c+3];
                    st[4*c]   = gf_mul(a, 8'd14) ^ gf_mul(b, 8'd11)
                                ^ gf_mul(d, 8'd13) ^ gf_mul(e, 8'd9);
                    st[4*c+1] = gf_mul(a, 8'd9) ^ gf_mul(b, 8'd14)
                                ^ gf_mul(d, 8'd11) ^ gf_mul(e, 8'd13);
                    st[4*c+2] = gf_mul(a, 8'd13) ^ gf_mul(b, 8'd9)
                                ^ gf_mul(d, 8'd14) ^ gf_mul(e, 8'd11);
                    st[4*c+3] = gf_mul(a, 8'd11) ^ gf_mul(b, 8'd13)
                                ^ gf_mul(d, 8'd9) ^ gf_mul(e, 8'd14);
                end
            end
        end
        for (int i = 0; i < 8; i++) begin
            res.hi[63 - 8*i -: 8] = st[i];
            res.lo[63 - 8*i -: 8] = st[8+i];
        end
        return res;
    endfunction

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("%0t: timeout with %0d blocks outstanding", $time, pending_blocks.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Output side: compare each transfer with the oldest expected block.
    always @(posedge aclk) begin
        block_pair_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_blocks.size() == 0) begin
                $display("%0t: unexpected output block, got %h %h", $time,
                         m_result_high, m_result_low);
                errors++;
            end else begin
                want = pending_blocks.pop_front();
                if (m_result_high !== want.hi) begin
                    $display("%0t: result_high expected %h actual %h", $time, want.hi,
                             m_result_high);
                    errors++;
                end
                if (m_result_low !== want.lo) begin
                    $display("%0t: result_low expected %h actual %h", $time, want.lo,
                             m_result_low);
                    errors++;
                end
                blocks_checked++;
            end
        end
    end

    // Output stall bursts, switched off in the tail of the run.
    initial begin
        int n;
        m_ready = 0;
        forever begin
            @(negedge aclk);
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                m_ready <= 0;
                n = $urandom_range(1, 13);
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_ready <= 1;
                n = $urandom_range(1, 20);
                repeat (n - 1) @(negedge aclk);
            end
        end
    end

    task automatic write_key_word(input cfg_index_t idx, input logic [63:0] value);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        key_words[idx] = value;
        @(negedge aclk);
    endtask

    task automatic load_key(input logic [255:0] key);
        write_key_word(CFG_KEY_WORD_0, key[255:192]);
        write_key_word(CFG_KEY_WORD_1, key[191:128]);
        write_key_word(CFG_KEY_WORD_2, key[127:64]);
        write_key_word(CFG_KEY_WORD_3, key[63:0]);
        cfg_valid <= 0;
        keys_used++;
    endtask

    task automatic send_block(input cmd_t cmd, input logic [63:0] hi, input logic [63:0] lo);
        int n;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 13);
            s_valid <= 0;
            repeat (n) @(negedge aclk);
        end
        pending_blocks.push_back(aes256_transform(cmd, hi, lo));
        s_valid <= 1;
        s_command <= cmd;
        s_block_high <= hi;
        s_block_low <= lo;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        blocks_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (pending_blocks.size() != 0) @(negedge aclk);
        repeat (PipeDepth + 5) @(negedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    vector_t directed [$];
    logic [255:0] fips_key = 256'h000102030405060708090a0b0c0d0e0f101112131415161718191a1b1c1d1e1f;

    initial begin
        block_pair_t got;
        logic [255:0] rk;
        aresetn = 0;
        cfg_valid = 0;
        cfg_index = CFG_KEY_WORD_0;
        cfg_data = '0;
        s_valid = 0;
        s_command = CMD_ENCRYPT;
        s_block_high = '0;
        s_block_low = '0;
        foreach (key_words[i]) key_words[i] = '0;
        build_sboxes();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Zero key straight after reset: well-known all-zero answer.
        directed = '{
            '{CMD_ENCRYPT, 64'h0, 64'h0, 1'b1, 64'hdc95c078a2408989, 64'had48a21492842087},
            '{CMD_DECRYPT, 64'hdc95c078a2408989, 64'had48a21492842087, 1'b1, 64'h0, 64'h0},
            '{CMD_ENCRYPT, '1, '1, 1'b0, '0, '0},
            '{CMD_DECRYPT, '1, '1, 1'b0, '0, '0},
            '{CMD_DECRYPT, 64'h0, 64'h0, 1'b0, '0, '0}
        };
        foreach (directed[i]) begin
            got = aes256_transform(directed[i].cmd, directed[i].hi, directed[i].lo);
            if (directed[i].known && (got.hi !== directed[i].exp_hi
                                      || got.lo !== directed[i].exp_lo)) begin
                $display("%0t: model zero-key vector %0d expected %h %h actual %h %h", $time,
                         i, directed[i].exp_hi, directed[i].exp_lo, got.hi, got.lo);
                errors++;
            end
            send_block(directed[i].cmd, directed[i].hi, directed[i].lo);
        end
        drain();

        // Standard AES-256 example key and block.
        load_key(fips_key);
        directed = '{
            '{CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
              64'h8ea2b7ca516745bf, 64'heafc49904b496089},
            '{CMD_DECRYPT, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1'b1,
              64'h0011223344556677, 64'h8899aabbccddeeff},
            '{CMD_ENCRYPT, 64'h8000000000000000, 64'h0, 1'b0, '0, '0},
            '{CMD_ENCRYPT, 64'h0, 64'h1, 1'b0, '0, '0},
            '{CMD_DECRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, '0, '0},
            '{CMD_ENCRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, '0, '0}
        };
        foreach (directed[i]) begin
            got = aes256_transform(directed[i].cmd, directed[i].hi, directed[i].lo);
            if (directed[i].known && (got.hi !== directed[i].exp_hi
                                      || got.lo !== directed[i].exp_lo)) begin
                $display("%0t: model example vector %0d expected %h %h actual %h %h", $time,
                         i, directed[i].exp_hi, directed[i].exp_lo, got.hi, got.lo);
                errors++;
            end
            send_block(directed[i].cmd, directed[i].hi, directed[i].lo);
        end
        drain();

        // All-ones key, then a set of random keys, each with a random mix.
        for (int phase = 0; phase < 7; phase++) begin
            if (phase == 0) rk = '1;
            else rk = {rand64(), rand64(), rand64(), rand64()};
            load_key(rk);
            for (int i = 0; i < 100; i++) begin
                if (phase == 6 && i == 50) quiet_tail = 1;
                send_block(cmd_t'($urandom_range(0, 1)), rand64(), rand64());
            end
            drain();
        end

        $display("Sent %0d blocks under %0d keys, checked %0d outputs in both directions.",
                 blocks_sent, keys_used + 1, blocks_checked);
        if (errors == 0 && pending_blocks.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

>>> aes256_block_cipher.f
hw/rtl/aes_pkg.sv
hw/rtl/aes_key_sched.sv
hw/rtl/aes_round.sv
hw/rtl/aes256_block_cipher.sv
tb/tb.sv
